// File: design/cbt_pkg.sv
package cbt_pkg;

  // Port field widths
  localparam int MODE_W = 2;
  localparam int IDX_W  = 10;
  localparam int FP_IN_W = 16;
  localparam int OCC_W  = 3;

  // Victim LFSR (Galois, right shift)
  localparam int          LFSR_W    = 16;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // Default table geometry
  localparam int NUM_BUCKETS_DEF      = 1024;
  localparam int SLOTS_PER_BUCKET_DEF = 4;
  localparam int FP_BITS_DEF          = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_COUNT  = 2'd3
  } mode_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_wr;  // write zero row at sweep address
    logic capture;   // latch request fields
    logic read;      // issue bucket row read
    logic update;    // write back modified row, load result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep address at last row
  } status_t;

endpackage

// File: design/cbt_ctrl.sv
module cbt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output cbt_pkg::cmd_t    cmd,
  input  cbt_pkg::status_t sts
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_load;

  // Result register is free or drains this cycle
  assign can_load = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (can_load) begin
          cmd.update = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_next  = ST_READ;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/cbt_dp.sv
module cbt_dp #(
  parameter int NUM_BUCKETS      = cbt_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = cbt_pkg::SLOTS_PER_BUCKET_DEF,
  parameter int FP_BITS          = cbt_pkg::FP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cbt_pkg::cmd_t                cmd,
  output cbt_pkg::status_t             sts,
  input  logic [cbt_pkg::MODE_W-1:0]   mode,
  input  logic [cbt_pkg::IDX_W-1:0]    bucket_index,
  input  logic [cbt_pkg::FP_IN_W-1:0]  fingerprint,
  input  logic                         eject,
  output logic                         success,
  output logic                         evicted_valid,
  output logic [cbt_pkg::FP_IN_W-1:0]  evicted_fp,
  output logic [cbt_pkg::OCC_W-1:0]    occupancy
);

  localparam int IDX_W   = cbt_pkg::IDX_W;
  localparam int LFSR_W  = cbt_pkg::LFSR_W;
  localparam int ADDR_W  = $clog2(NUM_BUCKETS);
  localparam int ROW_W   = SLOTS_PER_BUCKET * FP_BITS;
  localparam int SLOT_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int CNT_W   = $clog2(SLOTS_PER_BUCKET + 1);
  // Index reduction: q = floor(idx * RECIP / 2^RS) is the quotient or one less
  localparam int RS      = 2 * IDX_W;
  localparam int unsigned RECIP = (1 << RS) / NUM_BUCKETS;
  // Victim reduction: same scheme on the 16-bit LFSR value
  localparam int unsigned RV = (1 << LFSR_W) / SLOTS_PER_BUCKET;

  // Galois LFSR step
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] n;
    n = v >> 1;
    if (v[0]) begin
      n = n ^ cbt_pkg::LFSR_TAPS;
    end
    return n;
  endfunction

  // Request registers
  cbt_pkg::mode_t     req_mode;
  logic [IDX_W-1:0]   req_idx;
  logic [IDX_W-1:0]   req_q;
  logic [FP_BITS-1:0] req_fp;
  logic               req_eject;
  logic [IDX_W+RS-1:0] idx_prod;

  assign idx_prod = (IDX_W + RS)'(bucket_index) * (IDX_W + RS)'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode  <= cbt_pkg::mode_t'(mode);
      req_idx   <= bucket_index;
      req_q     <= idx_prod[RS +: IDX_W];
      req_fp    <= FP_BITS'(fingerprint);
      req_eject <= eject;
    end
  end

  // Bucket address: remainder with one correction step
  logic [IDX_W-1:0]  rem_raw;
  logic [IDX_W-1:0]  rem_fix;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    rem_raw = req_idx - IDX_W'(req_q * IDX_W'(NUM_BUCKETS));
    if (32'(rem_raw) >= 32'(NUM_BUCKETS)) begin
      rem_fix = rem_raw - IDX_W'(NUM_BUCKETS);
    end else begin
      rem_fix = rem_raw;
    end
    rd_addr = ADDR_W'(rem_fix);
  end

  // Clearing sweep counter
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign sts.clear_last = (clr_addr == ADDR_W'(NUM_BUCKETS - 1));

  // Bucket memory, one row per bucket
  logic [ROW_W-1:0]  mem [NUM_BUCKETS];
  logic [ROW_W-1:0]  rd_data;
  logic [ADDR_W-1:0] row_addr;
  logic [ROW_W-1:0]  new_row;

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[clr_addr] <= '0;
    end else if (cmd.update) begin
      mem[row_addr] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data  <= mem[rd_addr];
      row_addr <= rd_addr;
    end
  end

  // Victim LFSR and precomputed victim slot for the next eject
  logic [LFSR_W-1:0]   lfsr;
  logic [LFSR_W-1:0]   lfsr_d;
  logic [LFSR_W-1:0]   ahead;
  logic [2*LFSR_W:0]   vic_prod;
  logic [LFSR_W-1:0]   vic_a;
  logic [LFSR_W-1:0]   vic_q;
  logic [LFSR_W-1:0]   vic_rem;
  logic [SLOT_W-1:0]   victim;
  logic                lfsr_adv;

  assign lfsr_d   = lfsr_adv ? lfsr_step(lfsr) : lfsr;
  assign ahead    = lfsr_step(lfsr_d);
  assign vic_prod = (2 * LFSR_W + 1)'(ahead) * (2 * LFSR_W + 1)'(RV);
  assign vic_rem  = vic_a - LFSR_W'(vic_q * LFSR_W'(SLOTS_PER_BUCKET));

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= cbt_pkg::LFSR_SEED;
    end else begin
      lfsr <= lfsr_d;
    end
  end

  always_ff @(posedge clk) begin
    vic_a <= ahead;
    vic_q <= vic_prod[LFSR_W +: LFSR_W];
    if (vic_rem >= LFSR_W'(SLOTS_PER_BUCKET)) begin
      victim <= SLOT_W'(vic_rem - LFSR_W'(SLOTS_PER_BUCKET));
    end else begin
      victim <= SLOT_W'(vic_rem);
    end
  end

  // Slot compare and row update
  logic [FP_BITS-1:0] slot     [SLOTS_PER_BUCKET];
  logic [FP_BITS-1:0] slot_new [SLOTS_PER_BUCKET];
  logic [SLOTS_PER_BUCKET-1:0] empty;
  logic [SLOTS_PER_BUCKET-1:0] hit;
  logic [SLOT_W-1:0]  first_empty;
  logic [SLOT_W-1:0]  first_hit;
  logic               fp_nz;
  logic               res_success;
  logic               res_ev_valid;
  logic [FP_BITS-1:0] res_ev_fp;
  logic [CNT_W-1:0]   res_occ;

  always_comb begin
    fp_nz       = |req_fp;
    first_empty = '0;
    first_hit   = '0;
    res_occ     = '0;
    for (int j = 0; j < SLOTS_PER_BUCKET; j++) begin
      slot[j]     = rd_data[j*FP_BITS +: FP_BITS];
      slot_new[j] = slot[j];
      empty[j]    = (slot[j] == '0);
      hit[j]      = (slot[j] == req_fp);
      res_occ     = res_occ + CNT_W'(!empty[j]);
    end
    for (int j = SLOTS_PER_BUCKET - 1; j >= 0; j--) begin
      if (empty[j]) begin
        first_empty = SLOT_W'(j);
      end
      if (hit[j]) begin
        first_hit = SLOT_W'(j);
      end
    end

    res_success  = 1'b0;
    res_ev_valid = 1'b0;
    res_ev_fp    = '0;
    lfsr_adv     = 1'b0;
    case (req_mode)
      cbt_pkg::MODE_INSERT: begin
        if (fp_nz) begin
          if (|empty) begin
            slot_new[first_empty] = req_fp;
            res_success           = 1'b1;
          end else if (req_eject) begin
            res_ev_valid     = 1'b1;
            res_ev_fp        = slot[victim];
            slot_new[victim] = req_fp;
            lfsr_adv         = cmd.update;
          end
        end
      end
      cbt_pkg::MODE_LOOKUP: begin
        res_success = fp_nz && (|hit);
      end
      cbt_pkg::MODE_DELETE: begin
        if (fp_nz && (|hit)) begin
          slot_new[first_hit] = '0;
          res_success         = 1'b1;
        end
      end
      cbt_pkg::MODE_COUNT: begin
      end
      default: begin
      end
    endcase

    for (int j = 0; j < SLOTS_PER_BUCKET; j++) begin
      new_row[j*FP_BITS +: FP_BITS] = slot_new[j];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      success       <= res_success;
      evicted_valid <= res_ev_valid;
      evicted_fp    <= cbt_pkg::FP_IN_W'(res_ev_fp);
      if (req_mode == cbt_pkg::MODE_COUNT) begin
        occupancy <= cbt_pkg::OCC_W'(res_occ);
      end else begin
        occupancy <= '0;
      end
    end
  end

endmodule

// File: design/cuckoo_bucket_table_top.sv
// Cuckoo filter bucket table: one request in, one result out.
// A request is captured, its bucket row is read, then the row is written back and
// the result registered once the result register is free. A new request is
// accepted only when idle or alongside that write-back, as each request reads and
// then writes back a bucket row. Reset: a clearing pass writes every bucket row to
// empty, with in_ready low; the victim LFSR restarts from its seed.
module cuckoo_bucket_table_top #(
  parameter int NUM_BUCKETS      = cbt_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = cbt_pkg::SLOTS_PER_BUCKET_DEF,
  parameter int FP_BITS          = cbt_pkg::FP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cbt_pkg::MODE_W-1:0]   mode,
  input  logic [cbt_pkg::IDX_W-1:0]    bucket_index,
  input  logic [cbt_pkg::FP_IN_W-1:0]  fingerprint,
  input  logic                         eject,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         success,
  output logic                         evicted_valid,
  output logic [cbt_pkg::FP_IN_W-1:0]  evicted_fp,
  output logic [cbt_pkg::OCC_W-1:0]    occupancy
);

  cbt_pkg::cmd_t    cmd;
  cbt_pkg::status_t sts;

  // Sequencer
  cbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Bucket memory, compare and result datapath
  cbt_dp #(
    .NUM_BUCKETS      (NUM_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .FP_BITS          (FP_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .bucket_index  (bucket_index),
    .fingerprint   (fingerprint),
    .eject         (eject),
    .success       (success),
    .evicted_valid (evicted_valid),
    .evicted_fp    (evicted_fp),
    .occupancy     (occupancy)
  );

endmodule

// File: tb/sv/cuckoo_bucket_table_top_tb.sv
`timescale 1ns / 100ps

module cuckoo_bucket_table_top_tb;

  localparam int IDX_W        = cbt_pkg::IDX_W;
  localparam int FP_IN_W      = cbt_pkg::FP_IN_W;
  localparam int OCC_W        = cbt_pkg::OCC_W;
  localparam int LFSR_W       = cbt_pkg::LFSR_W;
  localparam int NUM_BUCKETS  = cbt_pkg::NUM_BUCKETS_DEF;
  localparam int SLOTS        = cbt_pkg::SLOTS_PER_BUCKET_DEF;
  localparam int HOT_BUCKETS  = 6;
  localparam int POOL_SIZE    = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_SLACK  = 10;

  // One expected result transaction
  typedef struct packed {
    logic                 success;
    logic                 evicted_valid;
    logic [FP_IN_W-1:0]   evicted_fp;
    logic [OCC_W-1:0]     occupancy;
  } bucket_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  cbt_pkg::mode_t     mode;
  logic [IDX_W-1:0]   bucket_index;
  logic [FP_IN_W-1:0] fingerprint;
  logic               eject;
  logic               out_valid;
  logic               out_ready;
  logic               success;
  logic               evicted_valid;
  logic [FP_IN_W-1:0] evicted_fp;
  logic [OCC_W-1:0]   occupancy;

  // Shadow copy of the bucket store and victim LFSR
  logic [FP_IN_W-1:0] bucket_slots [NUM_BUCKETS][SLOTS];
  logic [LFSR_W-1:0]  victim_lfsr;
  bucket_result_t     pending_results[$];
  bucket_result_t     expected_result;

  int mismatch_count  = 0;
  int cycle_count     = 0;
  int burst_left      = 0;
  bit sender_gaps     = 1'b1;
  int hold_off_cycles = 0;
  int rx_stall_pct    = 0;
  int rx_stretch      = 0;

  // Working set for the hot-bucket traffic
  logic [IDX_W-1:0]   hot_buckets [HOT_BUCKETS];
  logic [FP_IN_W-1:0] fp_pool [POOL_SIZE];

  cuckoo_bucket_table_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .bucket_index  (bucket_index),
    .fingerprint   (fingerprint),
    .eject         (eject),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .success       (success),
    .evicted_valid (evicted_valid),
    .evicted_fp    (evicted_fp),
    .occupancy     (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow store and return its result
  function automatic bucket_result_t apply_bucket_op(cbt_pkg::mode_t op,
                                                     logic [IDX_W-1:0] idx,
                                                     logic [FP_IN_W-1:0] fp, logic ej);
    bucket_result_t r;
    int b;
    int v;
    r = '0;
    b = idx % NUM_BUCKETS;
    if (op == cbt_pkg::MODE_COUNT) begin
      for (int j = 0; j < SLOTS; j++)
        if (bucket_slots[b][j] != '0) r.occupancy = r.occupancy + 1'b1;
    end else if (fp != '0) begin
      if (op == cbt_pkg::MODE_INSERT) begin
        // lowest empty slot wins
        for (int j = 0; j < SLOTS; j++) begin
          if (!r.success && bucket_slots[b][j] == '0) begin
            bucket_slots[b][j] = fp;
            r.success = 1'b1;
          end
        end
        // full bucket: swap out the slot picked by the stepped LFSR
        if (!r.success && ej) begin
          victim_lfsr = {1'b0, victim_lfsr[LFSR_W-1:1]} ^
                        (victim_lfsr[0] ? cbt_pkg::LFSR_TAPS : '0);
          v = victim_lfsr % SLOTS;
          r.evicted_valid = 1'b1;
          r.evicted_fp = bucket_slots[b][v];
          bucket_slots[b][v] = fp;
        end
      end else begin
        // lookup or delete: lowest matching slot
        for (int j = 0; j < SLOTS; j++) begin
          if (!r.success && bucket_slots[b][j] == fp) begin
            if (op == cbt_pkg::MODE_DELETE) bucket_slots[b][j] = '0;
            r.success = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // Drive one request transaction, with bursts and gaps on the input side
  task automatic send_request(cbt_pkg::mode_t op, logic [IDX_W-1:0] idx,
                              logic [FP_IN_W-1:0] fp, logic ej);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid     = 1'b1;
    mode         = op;
    bucket_index = idx;
    fingerprint  = fp;
    eject        = ej;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_bucket_op(op, idx, fp, ej));
  endtask

  task automatic idle_sender();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Pick a fresh set of hot buckets and a small fingerprint pool
  task automatic new_working_set();
    foreach (hot_buckets[i]) hot_buckets[i] = IDX_W'($urandom_range(0, NUM_BUCKETS - 1));
    hot_buckets[0] = ($urandom_range(0, 1) == 1) ? IDX_W'(NUM_BUCKETS - 1) : '0;
    foreach (fp_pool[i]) fp_pool[i] = FP_IN_W'($urandom_range(1, 16'hFFFF));
    fp_pool[0] = 16'h0001;
    fp_pool[1] = 16'hFFFF;
  endtask

  // Request on the working set; buckets fill, overflow and drain
  task automatic send_hot_request();
    cbt_pkg::mode_t     op;
    logic [IDX_W-1:0]   idx;
    logic [FP_IN_W-1:0] fp;
    int                 pick;
    idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, NUM_BUCKETS - 1))
                                      : hot_buckets[$urandom_range(0, HOT_BUCKETS - 1)];
    pick = $urandom_range(0, 19);
    if (pick == 0)      fp = '0;
    else if (pick == 1) fp = FP_IN_W'($urandom_range(1, 16'hFFFF));
    else                fp = fp_pool[$urandom_range(0, POOL_SIZE - 1)];
    pick = $urandom_range(0, 19);
    if (pick < 8)       op = cbt_pkg::MODE_INSERT;
    else if (pick < 13) op = cbt_pkg::MODE_LOOKUP;
    else if (pick < 17) op = cbt_pkg::MODE_DELETE;
    else                op = cbt_pkg::MODE_COUNT;
    send_request(op, idx, fp, 1'($urandom_range(0, 1)));
  endtask

  // Extremes of every field, each operation and each corner case
  task automatic test_directed();
    send_request(cbt_pkg::MODE_COUNT,  '0, 16'h0001, 1'b0);   // empty bucket
    send_request(cbt_pkg::MODE_LOOKUP, '0, 16'h0001, 1'b0);   // miss on empty bucket
    send_request(cbt_pkg::MODE_INSERT, '0, 16'h0000, 1'b1);   // zero fingerprint ignored
    send_request(cbt_pkg::MODE_LOOKUP, '0, 16'h0000, 1'b0);
    send_request(cbt_pkg::MODE_INSERT, 10'h3FF, 16'h0001, 1'b0);
    send_request(cbt_pkg::MODE_INSERT, 10'h3FF, 16'hFFFF, 1'b0);
    send_request(cbt_pkg::MODE_INSERT, 10'h3FF, 16'h8000, 1'b1);
    send_request(cbt_pkg::MODE_INSERT, 10'h3FF, 16'h1234, 1'b0);
    send_request(cbt_pkg::MODE_COUNT,  10'h3FF, 16'h0000, 1'b1);   // full bucket
    send_request(cbt_pkg::MODE_INSERT, 10'h3FF, 16'h00AA, 1'b0);   // full, no eject
    send_request(cbt_pkg::MODE_INSERT, 10'h3FF, 16'h0000, 1'b1);   // zero fp: LFSR holds
    send_request(cbt_pkg::MODE_INSERT, 10'h3FF, 16'h5555, 1'b1);   // eviction
    send_request(cbt_pkg::MODE_INSERT, 10'h3FF, 16'hAAAA, 1'b1);   // eviction
    send_request(cbt_pkg::MODE_LOOKUP, 10'h3FF, 16'h5555, 1'b0);
    send_request(cbt_pkg::MODE_DELETE, 10'h3FF, 16'hFFFF, 1'b0);
    send_request(cbt_pkg::MODE_DELETE, 10'h3FF, 16'h0000, 1'b0);   // zero fp delete
    send_request(cbt_pkg::MODE_COUNT,  10'h3FF, 16'hFFFF, 1'b0);
    send_request(cbt_pkg::MODE_INSERT, 10'h3FF, 16'h7777, 1'b1);
    // duplicates are allowed; one delete leaves the other copy
    send_request(cbt_pkg::MODE_INSERT, 10'h155, 16'h4321, 1'b0);
    send_request(cbt_pkg::MODE_INSERT, 10'h155, 16'h4321, 1'b0);
    send_request(cbt_pkg::MODE_DELETE, 10'h155, 16'h4321, 1'b1);
    send_request(cbt_pkg::MODE_LOOKUP, 10'h155, 16'h4321, 1'b0);
    send_request(cbt_pkg::MODE_DELETE, 10'h2AA, 16'h4321, 1'b0);   // miss
    send_request(cbt_pkg::MODE_COUNT,  10'h155, 16'h4321, 1'b0);
  endtask

  task automatic test_hot_bucket_traffic(int rounds, int per_round);
    repeat (rounds) begin
      new_working_set();
      repeat (per_round) send_hot_request();
    end
  endtask

  // Receiver held off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    new_working_set();
    sender_gaps = 1'b0;
    hold_off_cycles = 300;
    repeat (60) send_hot_request();
    sender_gaps = 1'b1;
  endtask

  // Sender stops until every result is back, then resumes
  task automatic test_sender_pause();
    new_working_set();
    repeat (25) send_hot_request();
    idle_sender();
    wait_results_drained();
    repeat (25) send_hot_request();
  endtask

  // Unconstrained fields over the whole range
  task automatic test_full_range_noise(int count);
    repeat (count)
      send_request(cbt_pkg::mode_t'($urandom_range(0, 3)),
                   IDX_W'($urandom_range(0, NUM_BUCKETS - 1)),
                   FP_IN_W'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
  endtask

  // Receiver stall pattern: stretches of fixed stall density, plus hold-off
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready = 1'b0;
        hold_off_cycles--;
      end else begin
        if (rx_stretch == 0) begin
          case ($urandom_range(0, 3))
            0: rx_stall_pct = 0;
            1: rx_stall_pct = 25;
            2: rx_stall_pct = 60;
            default: rx_stall_pct = 90;
          endcase
          rx_stretch = $urandom_range(10, 80);
        end
        rx_stretch--;
        out_ready = ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Result checker: each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        expected_result = pending_results.pop_front();
        if (success !== expected_result.success) begin
          $error("success: expected %0d, got %0d", expected_result.success, success);
          mismatch_count++;
        end
        if (evicted_valid !== expected_result.evicted_valid) begin
          $error("evicted_valid: expected %0d, got %0d",
                 expected_result.evicted_valid, evicted_valid);
          mismatch_count++;
        end
        if (evicted_fp !== expected_result.evicted_fp) begin
          $error("evicted_fp: expected %h, got %h", expected_result.evicted_fp, evicted_fp);
          mismatch_count++;
        end
        if (occupancy !== expected_result.occupancy) begin
          $error("occupancy: expected %0d, got %0d", expected_result.occupancy, occupancy);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("cuckoo_bucket_table_top verification failed");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = cbt_pkg::MODE_INSERT;
    bucket_index = '0;
    fingerprint  = '0;
    eject        = 1'b0;
    foreach (bucket_slots[i, j]) bucket_slots[i][j] = '0;
    victim_lfsr = cbt_pkg::LFSR_SEED;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_hot_bucket_traffic(6, 180);
    test_output_backpressure();
    test_sender_pause();
    test_hot_bucket_traffic(2, 150);
    test_full_range_noise(150);

    idle_sender();
    wait_results_drained();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("cuckoo_bucket_table_top verification clean");
    end else begin
      $display("cuckoo_bucket_table_top verification failed");
    end
    $finish;
  end

endmodule
